// ----- hw/rtl/mtnpw_pkg.sv -----
package mtnpw_pkg;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned LAYOUT_W  = 44;
   localparam int unsigned FIELD_W   = 11;
   localparam int unsigned ADDR_W    = 34;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned BE_W      = 4;
   localparam int unsigned MASK_W    = 8;
   localparam int unsigned DEPTH_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

   localparam logic [MASK_W-1:0] BIT_MASK_MSB = 8'h80;
   localparam logic [MASK_W-1:0] FULL_BYTE    = 8'hFF;
   localparam logic [2:0]        BIT_IN_BYTE  = 3'd7;

   localparam logic [BE_W-1:0] BE_ONE_BYTE    = 4'h1;
   localparam logic [BE_W-1:0] BE_TWO_BYTES   = 4'h3;
   localparam logic [BE_W-1:0] BE_THREE_BYTES = 4'h7;
   localparam logic [BE_W-1:0] BE_FOUR_BYTES  = 4'hF;

   localparam logic [DATA_W-1:0] DATA_MASK_16 = 32'h0000_FFFF;
   localparam logic [DATA_W-1:0] DATA_MASK_24 = 32'h00FF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_CODE     = 3'd0,
      CSR_CHANNEL_LAYOUT = 3'd1,
      CSR_LINE_PITCH     = 3'd2,
      CSR_X_PAN          = 3'd3,
      CSR_Y_PAN          = 3'd4,
      CSR_MONO01         = 3'd5,
      CSR_SURFACE_WIDTH  = 3'd6,
      CSR_SURFACE_HEIGHT = 3'd7
   } csr_index_type;

   localparam logic [DEPTH_W-1:0]  RESET_DEPTH_CODE     = DEPTH_32BPP;
   localparam logic [LAYOUT_W-1:0] RESET_CHANNEL_LAYOUT = 44'd34620424;
   localparam logic [COORD_W-1:0]  RESET_SURFACE_WIDTH  = 16'd640;
   localparam logic [COORD_W-1:0]  RESET_SURFACE_HEIGHT = 16'd480;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth_code;
      logic [LAYOUT_W-1:0] channel_layout;
      logic [COORD_W-1:0]  line_pitch;
      logic [COORD_W-1:0]  x_pan;
      logic [COORD_W-1:0]  y_pan;
      logic                mono01_polarity;
      logic [COORD_W-1:0]  surface_width;
      logic [COORD_W-1:0]  surface_height;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               shadow_bit;
   } pixel_type;

   typedef struct packed {
      logic [ADDR_W-1:0] fb_address;
      logic [DATA_W-1:0] write_data;
      logic [BE_W-1:0]   byte_enable;
      logic [MASK_W-1:0] bit_mask;
   } write_type;

   // Full-scale value of one channel at its offset; a length of 32 or more
   // fills the word and bits shifted past bit 31 are lost.
   function automatic logic [DATA_W-1:0] full_channel(input logic [FIELD_W-1:0] field);
      logic [5:0]        len;
      logic [4:0]        off;
      logic [DATA_W-1:0] maxv;
      len = field[5:0];
      off = field[10:6];
      if (len[5]) begin
         maxv = '1;
      end else begin
         maxv = ~({DATA_W{1'b1}} << len[4:0]);
      end
      return maxv << off;
   endfunction

endpackage

// ----- hw/rtl/mtnpw_if.sv -----
interface mtnpw_req_if;
   import mtnpw_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic               shadow_bit;

   modport source (output valid, output pixel_x, output pixel_y, output shadow_bit,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input shadow_bit,
                   output ready);
endinterface

interface mtnpw_rsp_if;
   import mtnpw_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] fb_address;
   logic [DATA_W-1:0] write_data;
   logic [BE_W-1:0]   byte_enable;
   logic [MASK_W-1:0] bit_mask;

   modport source (output valid, output fb_address, output write_data,
                   output byte_enable, output bit_mask, input ready);
   modport sink   (input valid, input fb_address, input write_data,
                   input byte_enable, input bit_mask, output ready);
endinterface

// ----- hw/rtl/mtnpw_csr.sv -----
module mtnpw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mtnpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mtnpw_pkg::LAYOUT_W-1:0]      csr_write_data,
   output mtnpw_pkg::cfg_type                  cfg
);
   import mtnpw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEPTH_CODE:     cfg_in.depth_code      = csr_write_data[DEPTH_W-1:0];
            CSR_CHANNEL_LAYOUT: cfg_in.channel_layout  = csr_write_data[LAYOUT_W-1:0];
            CSR_LINE_PITCH:     cfg_in.line_pitch      = csr_write_data[COORD_W-1:0];
            CSR_X_PAN:          cfg_in.x_pan           = csr_write_data[COORD_W-1:0];
            CSR_Y_PAN:          cfg_in.y_pan           = csr_write_data[COORD_W-1:0];
            CSR_MONO01:         cfg_in.mono01_polarity = csr_write_data[0];
            CSR_SURFACE_WIDTH:  cfg_in.surface_width   = csr_write_data[COORD_W-1:0];
            CSR_SURFACE_HEIGHT: cfg_in.surface_height  = csr_write_data[COORD_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_code      <= RESET_DEPTH_CODE;
         cfg_ff.channel_layout  <= RESET_CHANNEL_LAYOUT;
         cfg_ff.line_pitch      <= '0;
         cfg_ff.x_pan           <= '0;
         cfg_ff.y_pan           <= '0;
         cfg_ff.mono01_polarity <= 1'b0;
         cfg_ff.surface_width   <= RESET_SURFACE_WIDTH;
         cfg_ff.surface_height  <= RESET_SURFACE_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/mtnpw_pixel.sv -----
module mtnpw_pixel (
   input  mtnpw_pkg::cfg_type   cfg,
   input  mtnpw_pkg::pixel_type pixel,
   output logic                 keep,
   output mtnpw_pkg::write_type wr
);
   import mtnpw_pkg::*;

   logic [COORD_W:0]     row_sum;
   logic [2*COORD_W:0]   row_base;
   logic [COORD_W:0]     tx;
   logic [COORD_W+2:0]   tx_wide;
   logic [COORD_W+2:0]   col_offset;
   logic [DATA_W-1:0]    color;
   logic [DATA_W-1:0]    pix;
   logic                 white;

   always_comb begin
      keep = (pixel.pixel_x < cfg.surface_width) && (pixel.pixel_y < cfg.surface_height)
             && (cfg.depth_code <= DEPTH_32BPP);

      row_sum  = {1'b0, pixel.pixel_y} + {1'b0, cfg.y_pan};
      row_base = row_sum * cfg.line_pitch;
      tx       = {1'b0, pixel.pixel_x} + {1'b0, cfg.x_pan};
      tx_wide  = {2'b00, tx};

      color = full_channel(cfg.channel_layout[FIELD_W-1:0])
            | full_channel(cfg.channel_layout[2*FIELD_W-1:FIELD_W])
            | full_channel(cfg.channel_layout[3*FIELD_W-1:2*FIELD_W]);
      pix   = (pixel.shadow_bit ? '0 : color)
            | full_channel(cfg.channel_layout[4*FIELD_W-1:3*FIELD_W]);
      white = ~pixel.shadow_bit ^ cfg.mono01_polarity;

      wr.bit_mask = FULL_BYTE;
      case (cfg.depth_code)
         DEPTH_1BPP: begin
            col_offset        = tx_wide >> 3;
            wr.write_data     = {{(DATA_W-1){1'b0}}, white};
            wr.byte_enable    = BE_ONE_BYTE;
            wr.bit_mask       = BIT_MASK_MSB >> (tx[2:0] & BIT_IN_BYTE);
         end
         DEPTH_8BPP: begin
            col_offset        = tx_wide;
            wr.write_data     = pixel.shadow_bit ? '0 : {{(DATA_W-MASK_W){1'b0}}, FULL_BYTE};
            wr.byte_enable    = BE_ONE_BYTE;
         end
         DEPTH_16BPP: begin
            col_offset        = tx_wide << 1;
            wr.write_data     = pix & DATA_MASK_16;
            wr.byte_enable    = BE_TWO_BYTES;
         end
         DEPTH_24BPP: begin
            col_offset        = (tx_wide << 1) + tx_wide;
            wr.write_data     = pix & DATA_MASK_24;
            wr.byte_enable    = BE_THREE_BYTES;
         end
         default: begin
            col_offset        = tx_wide << 2;
            wr.write_data     = pix;
            wr.byte_enable    = BE_FOUR_BYTES;
         end
      endcase

      wr.fb_address = {1'b0, row_base} + {{(ADDR_W-COORD_W-3){1'b0}}, col_offset};
   end

endmodule

// ----- hw/rtl/mono_to_native_pixel_writer_core.sv -----
// A word accepted into the input register passes through the result register before its write shows on rsp.
// Throughput: one word per clock; the input register and the result register
// stall together only when a write waits on rsp and the input register is full.
// Words outside the surface or with an unused depth code give no write.
// Reset is synchronous and active high; it empties both registers and loads
// the configuration registers with their defaults.
module mono_to_native_pixel_writer_core (
   input  logic                            clock,
   input  logic                            reset,
   mtnpw_req_if.sink                       req,
   mtnpw_rsp_if.source                     rsp,
   input  logic                            csr_write_enable,
   input  logic [mtnpw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtnpw_pkg::LAYOUT_W-1:0]  csr_write_data
);
   import mtnpw_pkg::*;

   cfg_type   cfg;
   pixel_type pixel_ff;
   pixel_type pixel_in;
   logic      in_valid_ff;
   logic      in_valid_in;
   write_type wr;
   write_type wr_ff;
   write_type wr_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      keep;
   logic      advance;
   logic      accept;

   mtnpw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mtnpw_pixel u_pixel (
      .cfg   (cfg),
      .pixel (pixel_ff),
      .keep  (keep),
      .wr    (wr)
   );

   always_comb begin
      advance   = !out_valid_ff || rsp.ready;
      req.ready = !in_valid_ff || advance;
      accept    = req.valid && req.ready;

      in_valid_in = req.ready ? req.valid : in_valid_ff;
      pixel_in    = pixel_ff;
      if (accept) begin
         pixel_in = '{pixel_x: req.pixel_x, pixel_y: req.pixel_y, shadow_bit: req.shadow_bit};
      end

      out_valid_in = advance ? (in_valid_ff && keep) : out_valid_ff;
      wr_in        = (advance && in_valid_ff && keep) ? wr : wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      wr_ff    <= wr_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.fb_address  = wr_ff.fb_address;
   assign rsp.write_data  = wr_ff.write_data;
   assign rsp.byte_enable = wr_ff.byte_enable;
   assign rsp.bit_mask    = wr_ff.bit_mask;

endmodule

// ----- hw/rtl/mtnpw_checker.sv -----
module mtnpw_assertions (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mtnpw_pkg::ADDR_W-1:0]  rsp_fb_address,
   input logic [mtnpw_pkg::DATA_W-1:0]  rsp_write_data,
   input logic [mtnpw_pkg::BE_W-1:0]    rsp_byte_enable,
   input logic [mtnpw_pkg::MASK_W-1:0]  rsp_bit_mask
);
   import mtnpw_pkg::*;

   // A write that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fb_address)
         && $stable(rsp_write_data) && $stable(rsp_byte_enable) && $stable(rsp_bit_mask))
      else $error("stalled write changed");

   // A write appearing on an empty output comes from a word taken earlier through the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("write without a matching input word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_enable == BE_ONE_BYTE || rsp_byte_enable == BE_TWO_BYTES
         || rsp_byte_enable == BE_THREE_BYTES || rsp_byte_enable == BE_FOUR_BYTES)
      else $error("byte enables not a low-byte run");

   // Only a single-byte write may carry a partial bit mask, and then one bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_mask == FULL_BYTE
         || ($onehot(rsp_bit_mask) && rsp_byte_enable == BE_ONE_BYTE))
      else $error("bad bit mask");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("write shown after reset");

endmodule

bind mono_to_native_pixel_writer_core mtnpw_assertions u_mtnpw_assertions (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_fb_address  (rsp.fb_address),
   .rsp_write_data  (rsp.write_data),
   .rsp_byte_enable (rsp.byte_enable),
   .rsp_bit_mask    (rsp.bit_mask)
);

// ----- verif/mtnpw_checker.sv -----
// Watches the pixel and write channels and the register port, predicts every write
// from its own copy of the registers and compares each write word field by field.
module mtnpw_checker (
   input  logic                            clock,
   input  logic                            reset,
   mtnpw_req_if                            req,
   mtnpw_rsp_if                            rsp,
   input  logic                            csr_write_enable,
   input  logic [mtnpw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtnpw_pkg::LAYOUT_W-1:0]  csr_write_data,
   output int unsigned                     mismatch_count,
   output int unsigned                     writes_pending,
   output int unsigned                     pixels_taken,
   output int unsigned                     writes_checked
);
   import mtnpw_pkg::*;

   cfg_type     surface_cfg;
   write_type   expected_writes[$];
   int unsigned mismatches = 0;
   int unsigned pixels = 0;
   int unsigned checked = 0;

   function automatic logic [DATA_W-1:0] channel_fill(input logic [FIELD_W-1:0] field);
      logic [63:0] ones;
      if (field[5:0] == 6'd0) begin
         return '0;
      end
      ones = (field[5:0] >= 6'd32) ? 64'hFFFF_FFFF : (64'd1 << field[5:0]) - 64'd1;
      return DATA_W'(ones << field[10:6]);
   endfunction

   function automatic logic [DATA_W-1:0] paper_color(input cfg_type c, input bit paper);
      logic [DATA_W-1:0] color;
      color = '0;
      if (paper) begin
         color = channel_fill(c.channel_layout[10:0]) | channel_fill(c.channel_layout[21:11])
               | channel_fill(c.channel_layout[32:22]);
      end
      return color | channel_fill(c.channel_layout[43:33]);
   endfunction

   function automatic bit predict_write(input cfg_type c, input pixel_type p,
                                        output write_type w);
      logic [63:0] row_base;
      logic [63:0] column;
      logic [63:0] address;
      bit          paper;
      w = '0;
      if (p.pixel_x >= c.surface_width || p.pixel_y >= c.surface_height) begin
         return 1'b0;
      end
      if (c.depth_code > DEPTH_32BPP) begin
         return 1'b0;
      end
      row_base = (64'(p.pixel_y) + 64'(c.y_pan)) * 64'(c.line_pitch);
      column   = 64'(p.pixel_x) + 64'(c.x_pan);
      paper    = !p.shadow_bit;
      address  = row_base + column * 64'(c.depth_code);
      w.bit_mask = FULL_BYTE;
      case (c.depth_code)
         DEPTH_1BPP: begin
            address       = row_base + (column >> 3);
            w.write_data  = DATA_W'(paper ^ c.mono01_polarity);
            w.byte_enable = BE_ONE_BYTE;
            w.bit_mask    = BIT_MASK_MSB >> column[2:0];
         end
         DEPTH_8BPP: begin
            address       = row_base + column;
            w.write_data  = paper ? DATA_W'(FULL_BYTE) : '0;
            w.byte_enable = BE_ONE_BYTE;
         end
         DEPTH_16BPP: begin
            w.write_data  = paper_color(c, paper) & DATA_MASK_16;
            w.byte_enable = BE_TWO_BYTES;
         end
         DEPTH_24BPP: begin
            w.write_data  = paper_color(c, paper) & DATA_MASK_24;
            w.byte_enable = BE_THREE_BYTES;
         end
         default: begin
            w.write_data  = paper_color(c, paper);
            w.byte_enable = BE_FOUR_BYTES;
         end
      endcase
      w.fb_address = address[ADDR_W-1:0];
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_type pix;
      write_type want;
      write_type got;
      if (reset) begin
         surface_cfg = '{RESET_DEPTH_CODE, RESET_CHANNEL_LAYOUT, 16'd0, 16'd0, 16'd0, 1'b0,
                         RESET_SURFACE_WIDTH, RESET_SURFACE_HEIGHT};
         expected_writes.delete();
      end else begin
         if (req.valid && req.ready) begin
            pix = '{req.pixel_x, req.pixel_y, req.shadow_bit};
            pixels++;
            if (predict_write(surface_cfg, pix, want)) begin
               expected_writes.push_back(want);
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.fb_address, rsp.write_data, rsp.byte_enable, rsp.bit_mask};
            if (expected_writes.size() == 0) begin
               mismatches++;
               $display("%0t: write word with none expected, got %h %h %h %h", $time,
                        got.fb_address, got.write_data, got.byte_enable, got.bit_mask);
            end else begin
               want = expected_writes.pop_front();
               checked++;
               check_field("fb_address", 64'(want.fb_address), 64'(got.fb_address));
               check_field("write_data", 64'(want.write_data), 64'(got.write_data));
               check_field("byte_enable", 64'(want.byte_enable), 64'(got.byte_enable));
               check_field("bit_mask", 64'(want.bit_mask), 64'(got.bit_mask));
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_DEPTH_CODE:     surface_cfg.depth_code      = csr_write_data[DEPTH_W-1:0];
               CSR_CHANNEL_LAYOUT: surface_cfg.channel_layout  = csr_write_data;
               CSR_LINE_PITCH:     surface_cfg.line_pitch      = csr_write_data[COORD_W-1:0];
               CSR_X_PAN:          surface_cfg.x_pan           = csr_write_data[COORD_W-1:0];
               CSR_Y_PAN:          surface_cfg.y_pan           = csr_write_data[COORD_W-1:0];
               CSR_MONO01:         surface_cfg.mono01_polarity = csr_write_data[0];
               CSR_SURFACE_WIDTH:  surface_cfg.surface_width   = csr_write_data[COORD_W-1:0];
               default:            surface_cfg.surface_height  = csr_write_data[COORD_W-1:0];
            endcase
         end
      end
      mismatch_count <= mismatches;
      writes_pending <= expected_writes.size();
      pixels_taken   <= pixels;
      writes_checked <= checked;
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;
   import mtnpw_pkg::*;

   localparam int unsigned HALF_PERIOD    = 6;
   localparam int unsigned RESET_CYCLES   = 12;
   localparam int unsigned PIXEL_TARGET   = 1850;
   localparam int unsigned PHASE_PIXELS   = 160;
   localparam int unsigned SQUEEZE_PHASE  = 2;
   localparam int unsigned SQUEEZE_CYCLES = 150;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned DRAIN_LIMIT    = 5000;
   localparam int unsigned TIMEOUT_CYCLES = 400000;

   typedef enum int unsigned {RX_STREAM, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_style_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LAYOUT_W-1:0]  csr_write_data;

   int unsigned mismatch_count;
   int unsigned writes_pending;
   int unsigned pixels_taken;
   int unsigned writes_checked;

   cfg_type     active_cfg;
   int unsigned burst_left = 0;
   int unsigned settings_used = 0;
   bit          squeeze_request = 1'b0;

   mtnpw_req_if pixel_ch();
   mtnpw_rsp_if write_ch();

   mono_to_native_pixel_writer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (pixel_ch),
      .rsp              (write_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mtnpw_checker write_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (pixel_ch),
      .rsp              (write_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .writes_pending   (writes_pending),
      .pixels_taken     (pixels_taken),
      .writes_checked   (writes_checked)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [FIELD_W-1:0] channel_field(input int unsigned len,
                                                        input int unsigned offset);
      return {5'(offset), 6'(len)};
   endfunction

   function automatic cfg_type base_setting();
      return '{RESET_DEPTH_CODE, RESET_CHANNEL_LAYOUT, 16'd0, 16'd0, 16'd0, 1'b0,
               RESET_SURFACE_WIDTH, RESET_SURFACE_HEIGHT};
   endfunction

   function automatic logic [COORD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return COORD_W'($urandom_range(0, 255));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_extent();
      case ($urandom_range(0, 9))
         0:       return COORD_W'(1);
         1:       return '1;
         2, 3:    return COORD_W'($urandom_range(1, 16));
         default: return COORD_W'($urandom_range(1, 65535));
      endcase
   endfunction

   // Most coordinates land inside the surface, some exactly on its edge.
   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] extent);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 8 && extent != 0) begin
         return COORD_W'($urandom_range(0, int'(extent) - 1));
      end
      if (roll == 8) begin
         return extent;
      end
      return COORD_W'($urandom);
   endfunction

   function automatic logic [LAYOUT_W-1:0] common_layout();
      case ($urandom_range(0, 3))
         0:       return RESET_CHANNEL_LAYOUT;
         1:       return {channel_field(8, 24), channel_field(8, 0), channel_field(8, 8),
                          channel_field(8, 16)};
         2:       return {channel_field(0, 0), channel_field(5, 0), channel_field(6, 5),
                          channel_field(5, 11)};
         default: return {channel_field(0, 0), channel_field(8, 16), channel_field(8, 8),
                          channel_field(8, 0)};
      endcase
   endfunction

   function automatic cfg_type random_setting(input int unsigned phase);
      cfg_type s;
      if (phase == 0) begin
         s = '{DEPTH_32BPP, '1, '1, '1, '1, 1'b1, '1, '1};
      end else if (phase == 1) begin
         s = '{DEPTH_1BPP, '0, '0, '0, '0, 1'b0, COORD_W'(1), COORD_W'(1)};
      end else begin
         s.depth_code      = ($urandom_range(0, 9) == 0) ? DEPTH_W'($urandom_range(5, 7))
                                                         : DEPTH_W'($urandom_range(0, 4));
         s.channel_layout  = $urandom_range(0, 1) ? LAYOUT_W'({$urandom, $urandom})
                                                  : common_layout();
         s.line_pitch      = pick_value();
         s.x_pan           = pick_value();
         s.y_pan           = pick_value();
         s.mono01_polarity = 1'($urandom);
         s.surface_width   = pick_extent();
         s.surface_height  = pick_extent();
      end
      if (phase == SQUEEZE_PHASE) begin
         s.depth_code     = DEPTH_W'($urandom_range(0, 4));
         s.surface_width  = '1;
         s.surface_height = '1;
      end
      return s;
   endfunction

   task automatic write_reg(input csr_index_type index, input logic [LAYOUT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_type s);
      write_reg(CSR_DEPTH_CODE, LAYOUT_W'(s.depth_code));
      write_reg(CSR_CHANNEL_LAYOUT, s.channel_layout);
      write_reg(CSR_LINE_PITCH, LAYOUT_W'(s.line_pitch));
      write_reg(CSR_X_PAN, LAYOUT_W'(s.x_pan));
      write_reg(CSR_Y_PAN, LAYOUT_W'(s.y_pan));
      write_reg(CSR_MONO01, LAYOUT_W'(s.mono01_polarity));
      write_reg(CSR_SURFACE_WIDTH, LAYOUT_W'(s.surface_width));
      write_reg(CSR_SURFACE_HEIGHT, LAYOUT_W'(s.surface_height));
      csr_write_enable <= 1'b0;
      active_cfg = s;
      settings_used++;
   endtask

   // Dropped pixels leave no trace, so a settling wait covers any still in flight.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      pixel_ch.valid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic ink);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            pixel_ch.valid      <= 1'b0;
            pixel_ch.pixel_x    <= COORD_W'($urandom);
            pixel_ch.pixel_y    <= COORD_W'($urandom);
            pixel_ch.shadow_bit <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pixel_ch.valid      <= 1'b1;
      pixel_ch.pixel_x    <= x;
      pixel_ch.pixel_y    <= y;
      pixel_ch.shadow_bit <= ink;
      @(posedge clock);
      while (!pixel_ch.ready) @(posedge clock);
   endtask

   initial begin : receiver
      rx_style_type style;
      int unsigned  style_left;
      int unsigned  hold_left;
      logic         next_ready;
      style      = RX_STREAM;
      style_left = 0;
      hold_left  = 0;
      write_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (style_left == 0) begin
            style      = rx_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 300);
         end
         style_left--;
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            hold_left       = SQUEEZE_CYCLES;
         end
         case (style)
            RX_STREAM:  next_ready = 1'b1;
            RX_LIGHT:   next_ready = ($urandom_range(0, 9) < 7);
            RX_PATTERN: next_ready = (style_left % 4 != 0);
            default:    next_ready = ($urandom_range(0, 9) < 3);
         endcase
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end
         write_ch.ready <= next_ready;
      end
   end

   initial begin : stimulus
      cfg_type              s;
      int unsigned          phase;
      int unsigned          sent;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      reset               <= 1'b1;
      pixel_ch.valid      <= 1'b0;
      pixel_ch.pixel_x    <= '0;
      pixel_ch.pixel_y    <= '0;
      pixel_ch.shadow_bit <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_DEPTH_CODE;
      csr_write_data      <= '0;
      active_cfg = base_setting();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pixel(16'd0, 16'd0, 1'b1);
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'd639, 16'd479, 1'b0);
      send_pixel(16'd640, 16'd0, 1'b0);
      send_pixel(16'd0, 16'd480, 1'b1);
      send_pixel(16'hFFFF, 16'hFFFF, 1'b0);

      settle();
      s = '{DEPTH_1BPP, RESET_CHANNEL_LAYOUT, '1, '1, '1, 1'b0, '1, '1};
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'hFFFE, 16'hFFFE, 1'b1);
      send_pixel(16'd7, 16'd3, 1'b0);
      send_pixel(16'd5, 16'd1, 1'b1);

      settle();
      s.mono01_polarity = 1'b1;
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'd2, 16'd0, 1'b1);

      settle();
      s = '{DEPTH_8BPP, RESET_CHANNEL_LAYOUT, '0, '0, '0, 1'b0, COORD_W'(1), COORD_W'(1)};
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b1);
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'd1, 16'd0, 1'b0);
      send_pixel(16'd0, 16'd1, 1'b1);

      // An alpha length beyond 32 counts as a full word.
      settle();
      s = base_setting();
      s.depth_code     = DEPTH_16BPP;
      s.line_pitch     = 16'd1280;
      s.channel_layout = {channel_field(63, 0), channel_field(5, 0), channel_field(6, 5),
                          channel_field(5, 11)};
      apply_setting(s);
      send_pixel(16'd3, 16'd2, 1'b0);
      send_pixel(16'd3, 16'd2, 1'b1);

      settle();
      s.depth_code     = DEPTH_24BPP;
      s.channel_layout = {channel_field(0, 0), channel_field(1, 0), channel_field(0, 0),
                          channel_field(32, 31)};
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'd0, 16'd0, 1'b1);

      settle();
      s.depth_code = DEPTH_W'(5);
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b0);

      settle();
      s.depth_code = '1;
      apply_setting(s);
      send_pixel(16'd1, 16'd1, 1'b1);

      settle();
      s = base_setting();
      s.surface_width  = '0;
      s.surface_height = '0;
      apply_setting(s);
      send_pixel(16'd0, 16'd0, 1'b0);

      phase = 0;
      sent  = 0;
      while (sent < PIXEL_TARGET) begin
         settle();
         apply_setting(random_setting(phase));
         if (phase == SQUEEZE_PHASE) begin
            squeeze_request = 1'b1;
         end
         repeat (PHASE_PIXELS) begin
            x = pick_coord(active_cfg.surface_width);
            y = pick_coord(active_cfg.surface_height);
            send_pixel(x, y, 1'($urandom));
            sent++;
         end
         phase++;
      end
      settle();

      $display("Sent %0d pixel words under %0d register settings; %0d writes checked.",
               pixels_taken, settings_used, writes_checked);
      if (mismatch_count == 0 && writes_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d expected writes never arrived.",
                  mismatch_count, writes_pending);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("Timed out with %0d writes still expected.", writes_pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
